FILE: rtl/core/bounded_list_deque_search_top_assert.svh
// Assertion macros for the bounded list deque search block.
`ifndef BOUNDED_LIST_DEQUE_SEARCH_TOP_ASSERT_SVH
`define BOUNDED_LIST_DEQUE_SEARCH_TOP_ASSERT_SVH

// Condition holds at every edge out of reset.
`define BLDQ_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication.
`define BLDQ_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define BLDQ_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/bldq_pkg.sv
// Shared field widths, command codes and status codes for the deque search block.
package bldq_pkg;

  localparam int MODE_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 6;
  localparam int COUNT_W  = 6;

  localparam int MAX_RESULTS = 32;
  localparam int MATCH_W     = 6;

  localparam logic [MODE_W-1:0] MODE_PUSH_HEAD = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_TAIL = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_HEAD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_TAIL  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SEARCH    = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef logic [VALUE_W-1:0] value_t;

endpackage

FILE: rtl/core/bounded_list_deque_search_top.sv
// Bounded deque of signed 32-bit values with a linear search walk.
// Push and remove commands give one registered result beat.
// A search walks the list from the head through the single read port of the
// entry RAM, one entry per cycle unless a match is stalled at the result
// side, and holds the command channel until its last beat is loaded.
// Each match is held one step so the final one can be marked last; a search
// with no match gives one not-found beat. Entries never written read as
// undefined, but only occupied slots are ever searched.
module bounded_list_deque_search_top #(
  parameter int DEPTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  output logic                            cmd_ready,
  input  logic [bldq_pkg::MODE_W-1:0]     mode,
  input  logic signed [bldq_pkg::VALUE_W-1:0] value,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output logic [bldq_pkg::STATUS_W-1:0]   status,
  output logic                            found,
  output logic [bldq_pkg::POS_W-1:0]      position,
  output logic [bldq_pkg::COUNT_W-1:0]    count,
  output logic                            last
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);
  localparam logic [bldq_pkg::MATCH_W-1:0] MATCH_CAP =
    bldq_pkg::MATCH_W'(bldq_pkg::MAX_RESULTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]                     state;
  logic [AW-1:0]                  head_index;
  logic [CW-1:0]                  entry_count;
  bldq_pkg::value_t               key;
  logic [AW-1:0]                  rd_ptr;
  logic [CW-1:0]                  rd_pos;
  logic                           cmp_valid;
  logic [CW-1:0]                  cmp_pos;
  logic                           pend_valid;
  logic [CW-1:0]                  pend_pos;
  logic [bldq_pkg::MATCH_W-1:0]   nmatch;

  logic                           out_free;
  logic                           accept;
  logic                           is_full;
  logic                           is_empty;
  logic [AW-1:0]                  head_dec;
  logic [AW-1:0]                  head_inc;
  logic [AW-1:0]                  ptr_inc;
  logic [AW:0]                    tail_sum;
  logic [AW-1:0]                  tail_slot;
  logic                           hit;
  logic                           stall;
  logic                           walk_issue;
  logic                           walk_done;
  logic                           rsp_load;
  logic                           wr_en;
  logic [AW-1:0]                  wr_addr;
  bldq_pkg::value_t               rd_data;

  logic                           acc_emit;
  logic                           acc_search;
  logic [bldq_pkg::STATUS_W-1:0]  acc_status;
  logic [CW-1:0]                  count_next;
  logic [AW-1:0]                  head_next;

  assign out_free  = !rsp_valid || rsp_ready;
  assign cmd_ready = (state == S_IDLE) && out_free;
  assign accept    = cmd_valid && cmd_ready;
  assign is_full   = (entry_count == DEPTH_C);
  assign is_empty  = (entry_count == '0);

  assign head_dec  = (head_index == '0) ? LAST_SLOT : head_index - 1'b1;
  assign head_inc  = (head_index == LAST_SLOT) ? '0 : head_index + 1'b1;
  assign ptr_inc   = (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
  assign tail_sum  = (AW + 1)'(head_index) + (AW + 1)'(entry_count);
  assign tail_slot = (tail_sum >= DEPTH_W) ? AW'(tail_sum - DEPTH_W) : AW'(tail_sum);

  assign hit        = cmp_valid && (rd_data == key) && (nmatch < MATCH_CAP);
  assign stall      = hit && pend_valid && !out_free;
  assign walk_issue = (state == S_WALK) && (rd_pos != entry_count) && !stall;
  assign walk_done  = (state == S_WALK) && (rd_pos == entry_count) && !cmp_valid;

  assign rsp_load = (accept && acc_emit) ||
                    ((state == S_WALK) && hit && pend_valid && !stall) ||
                    ((state == S_FLUSH) && out_free);

  assign wr_en   = accept && !is_full &&
                   ((mode == bldq_pkg::MODE_PUSH_HEAD) || (mode == bldq_pkg::MODE_PUSH_TAIL));
  assign wr_addr = (mode == bldq_pkg::MODE_PUSH_HEAD) ? head_dec : tail_slot;

  always_comb begin
    acc_emit   = 1'b1;
    acc_search = 1'b0;
    acc_status = bldq_pkg::ST_OK;
    count_next = entry_count;
    head_next  = head_index;
    case (mode)
      bldq_pkg::MODE_PUSH_HEAD: begin
        if (is_full) begin
          acc_status = bldq_pkg::ST_FULL;
        end else begin
          head_next  = head_dec;
          count_next = entry_count + 1'b1;
        end
      end
      bldq_pkg::MODE_PUSH_TAIL: begin
        if (is_full) begin
          acc_status = bldq_pkg::ST_FULL;
        end else begin
          count_next = entry_count + 1'b1;
        end
      end
      bldq_pkg::MODE_POP_HEAD: begin
        if (is_empty) begin
          acc_status = bldq_pkg::ST_EMPTY;
        end else begin
          head_next  = head_inc;
          count_next = entry_count - 1'b1;
        end
      end
      bldq_pkg::MODE_POP_TAIL: begin
        if (is_empty) begin
          acc_status = bldq_pkg::ST_EMPTY;
        end else begin
          count_next = entry_count - 1'b1;
        end
      end
      bldq_pkg::MODE_SEARCH: begin
        if (is_empty) begin
          acc_status = bldq_pkg::ST_EMPTY;
        end else begin
          acc_emit   = 1'b0;
          acc_search = 1'b1;
        end
      end
      default: begin
        acc_status = bldq_pkg::ST_OK;
      end
    endcase
  end

  bldq_ram #(
    .WIDTH (bldq_pkg::VALUE_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value),
    .rd_en   (walk_issue),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head_index  <= '0;
      entry_count <= '0;
      rsp_valid   <= 1'b0;
      cmp_valid   <= 1'b0;
      pend_valid  <= 1'b0;
      nmatch      <= '0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            head_index  <= head_next;
            entry_count <= count_next;
            if (acc_emit) begin
              status    <= acc_status;
              found     <= 1'b0;
              position  <= '0;
              count     <= bldq_pkg::COUNT_W'(count_next);
              last      <= 1'b1;
            end
            if (acc_search) begin
              state      <= S_WALK;
              key        <= value;
              rd_ptr     <= head_index;
              rd_pos     <= '0;
              cmp_valid  <= 1'b0;
              pend_valid <= 1'b0;
              nmatch     <= '0;
            end
          end
        end
        S_WALK: begin
          if (!stall) begin
            cmp_valid <= walk_issue;
            if (walk_issue) begin
              rd_ptr  <= ptr_inc;
              rd_pos  <= rd_pos + 1'b1;
              cmp_pos <= rd_pos + 1'b1;
            end
            if (hit) begin
              // earlier match goes out now, it is known not to be the final one
              if (pend_valid) begin
                status    <= bldq_pkg::ST_OK;
                found     <= 1'b1;
                position  <= bldq_pkg::POS_W'(pend_pos);
                count     <= bldq_pkg::COUNT_W'(entry_count);
                last      <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_pos   <= cmp_pos;
              nmatch     <= nmatch + 1'b1;
            end
          end
          if (walk_done) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            status     <= bldq_pkg::ST_OK;
            found      <= pend_valid;
            position   <= pend_valid ? bldq_pkg::POS_W'(pend_pos) : '0;
            count      <= bldq_pkg::COUNT_W'(entry_count);
            last       <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`include "bounded_list_deque_search_top_assert.svh"

  `BLDQ_CHECK(a_count_bound, entry_count <= DEPTH_C, "entry count above depth")
  `BLDQ_IMPLY(a_nonmatch_last, rsp_valid && !found, last, "non-match beat not marked last")
  `BLDQ_IMPLY(a_pend_counted, pend_valid, nmatch != '0, "held match not counted")
  `BLDQ_NEXT(a_walk_holds_list, state != S_IDLE, $stable(entry_count) && $stable(head_index), "list changed during search")

endmodule

FILE: rtl/core/bldq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bldq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                      wr_data,
  input  logic                                  rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
